// ----- sv/cdam_pkg.sv -----
// shared types and constants for the concatenated device address map
package cdam_pkg;

  localparam int ADDR_W  = 64;
  localparam int SIZE_W  = 48;
  localparam int ENTRY_W = 3;
  localparam int HIT_W   = 3;
  localparam int CNT_W   = 4;

  localparam logic [CNT_W-1:0]  CNT_RESET = CNT_W'(1);
  localparam logic [ADDR_W-1:0] ALL_ONES  = '1;

  // item operation codes
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FWD  = 2'd1,
    OP_REV  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // control that travels with each item down the pipe
  typedef struct packed {
    logic vld;
    op_t  op;
  } stage_ctl_t;

  // table write request carried by a load
  typedef struct packed {
    logic               en;
    logic [ENTRY_W-1:0] idx;
    logic [ADDR_W-1:0]  base;
    logic [SIZE_W-1:0]  size;
  } tbl_wr_t;

endpackage

// ----- sv/cdam_table.sv -----
// device table storage with prefix-sum rebuild sequencer
module cdam_table #(
  parameter int MAX_DEVICES = 8,
  localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1,
  localparam int SUM_W = cdam_pkg::SIZE_W + $clog2(MAX_DEVICES) + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cdam_pkg::tbl_wr_t       wr,
  input  logic [IDX_W-1:0]        rd_idx,
  output logic [cdam_pkg::ADDR_W-1:0] base_q   [MAX_DEVICES],
  output logic [cdam_pkg::SIZE_W-1:0] size_q   [MAX_DEVICES],
  output logic [SUM_W-1:0]        prefix_q [MAX_DEVICES],
  output logic [cdam_pkg::ADDR_W-1:0] rd_base,
  output logic [SUM_W-1:0]        rd_prefix,
  output logic                    sweep_last
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_DEVICES - 1);

  logic [cdam_pkg::ADDR_W-1:0] base_r   [MAX_DEVICES];
  logic [cdam_pkg::SIZE_W-1:0] size_r   [MAX_DEVICES];
  logic [SUM_W-1:0]            prefix_r [MAX_DEVICES];

  logic             sweep_act_r;
  logic [IDX_W-1:0] cnt_r;
  logic [SUM_W-1:0] acc_r;
  logic             wr_ok;

  assign wr_ok = wr.en && (32'(wr.idx) < 32'(MAX_DEVICES));

  // entry storage, written by a load and by the rebuild sweep
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      base_r[IDX_W'(wr.idx)] <= wr.base;
      size_r[IDX_W'(wr.idx)] <= wr.size;
    end
    if (sweep_act_r) begin
      prefix_r[cnt_r] <= acc_r;
    end
  end

  // rebuild sweep: one entry per cycle, running sum of earlier sizes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_act_r <= 1'b0;
      cnt_r       <= '0;
    end else if (wr.en) begin
      sweep_act_r <= 1'b1;
      cnt_r       <= '0;
    end else if (sweep_act_r) begin
      cnt_r <= cnt_r + IDX_W'(1);
      if (cnt_r == LAST) begin
        sweep_act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      acc_r <= '0;
    end else if (sweep_act_r) begin
      acc_r <= acc_r + SUM_W'(size_r[cnt_r]);
    end
  end

  assign sweep_last = sweep_act_r && (cnt_r == LAST);
  assign base_q     = base_r;
  assign size_q     = size_r;
  assign prefix_q   = prefix_r;
  assign rd_base    = base_r[rd_idx];
  assign rd_prefix  = prefix_r[rd_idx];

  // a second load never lands while a rebuild is running
  a_no_wr_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> !sweep_act_r)
    else $error("table write during prefix rebuild");

endmodule

// ----- sv/cdam_match.sv -----
// per-device window compare and first-hit select, two register stages
module cdam_match #(
  parameter int MAX_DEVICES = 8,
  localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1,
  localparam int SUM_W = cdam_pkg::SIZE_W + $clog2(MAX_DEVICES) + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cdam_pkg::stage_ctl_t        s0_ctl,
  input  logic [cdam_pkg::ADDR_W-1:0] s0_query,
  input  cdam_pkg::tbl_wr_t           s0_wr,
  input  logic [cdam_pkg::CNT_W-1:0]  dev_count,
  input  logic [cdam_pkg::ADDR_W-1:0] base_q   [MAX_DEVICES],
  input  logic [cdam_pkg::SIZE_W-1:0] size_q   [MAX_DEVICES],
  input  logic [SUM_W-1:0]            prefix_q [MAX_DEVICES],
  output cdam_pkg::stage_ctl_t        s2_ctl,
  output cdam_pkg::tbl_wr_t           s2_wr,
  output logic                        s2_found,
  output logic [IDX_W-1:0]            s2_idx,
  output logic [cdam_pkg::SIZE_W-1:0] s2_diff
);

  cdam_pkg::stage_ctl_t        s1_ctl_r, s2_ctl_r;
  cdam_pkg::tbl_wr_t           s1_wr_r, s2_wr_r;
  logic [MAX_DEVICES-1:0]      hit_w, hit_r;
  logic [cdam_pkg::SIZE_W-1:0] diff_r [MAX_DEVICES];
  logic [cdam_pkg::ADDR_W-1:0] key_w  [MAX_DEVICES];
  logic [cdam_pkg::ADDR_W-1:0] dist_w [MAX_DEVICES];
  logic                        is_query;
  logic                        found_w;
  logic [IDX_W-1:0]            idx_w;
  logic                        s2_found_r;
  logic [IDX_W-1:0]            s2_idx_r;
  logic [cdam_pkg::SIZE_W-1:0] s2_diff_r;

  assign is_query = (s0_ctl.op == cdam_pkg::OP_FWD) || (s0_ctl.op == cdam_pkg::OP_REV);

  // window test per device: key is the running offset or the base address
  always_comb begin
    for (int i = 0; i < MAX_DEVICES; i++) begin
      key_w[i]  = (s0_ctl.op == cdam_pkg::OP_FWD) ? cdam_pkg::ADDR_W'(prefix_q[i]) : base_q[i];
      dist_w[i] = s0_query - key_w[i];
      hit_w[i]  = is_query && (i < int'(dev_count)) && (s0_query >= key_w[i]) &&
                  (dist_w[i] < cdam_pkg::ADDR_W'(size_q[i]));
    end
  end

  // first matching device in table order
  always_comb begin
    found_w = |hit_r;
    idx_w   = '0;
    for (int i = MAX_DEVICES - 1; i >= 0; i--) begin
      if (hit_r[i]) begin
        idx_w = IDX_W'(i);
      end
    end
  end

  // stage payload, with valid bits cleared by reset
  always_ff @(posedge clk) begin
    s1_ctl_r.op   <= s0_ctl.op;
    s1_wr_r.idx   <= s0_wr.idx;
    s1_wr_r.base  <= s0_wr.base;
    s1_wr_r.size  <= s0_wr.size;
    hit_r         <= hit_w;
    for (int i = 0; i < MAX_DEVICES; i++) begin
      diff_r[i] <= dist_w[i][cdam_pkg::SIZE_W-1:0];
    end
    s2_ctl_r.op   <= s1_ctl_r.op;
    s2_wr_r.idx   <= s1_wr_r.idx;
    s2_wr_r.base  <= s1_wr_r.base;
    s2_wr_r.size  <= s1_wr_r.size;
    s2_found_r    <= found_w;
    s2_idx_r      <= idx_w;
    s2_diff_r     <= diff_r[idx_w];
    if (!rst_n) begin
      s1_ctl_r.vld <= 1'b0;
      s2_ctl_r.vld <= 1'b0;
      s1_wr_r.en   <= 1'b0;
      s2_wr_r.en   <= 1'b0;
    end else begin
      s1_ctl_r.vld <= s0_ctl.vld;
      s2_ctl_r.vld <= s1_ctl_r.vld;
      s1_wr_r.en   <= s0_wr.en;
      s2_wr_r.en   <= s1_wr_r.en;
    end
  end

  assign s2_ctl   = s2_ctl_r;
  assign s2_wr    = s2_wr_r;
  assign s2_found = s2_found_r;
  assign s2_idx   = s2_idx_r;
  assign s2_diff  = s2_diff_r;

endmodule

// ----- sv/concat_device_address_map.sv -----
// top level of the concatenated device address map
// path: a transfer is registered in the input stage, match stages s1 and s2, and the output stage
// throughput: queries one per cycle while busy is low; a load holds busy until
//   the prefix-sum rebuild, which walks the table one entry per cycle, ends
// reset: synchronous, active low; clears pipe valids, busy and device_count to 1
// table contents are undefined until loaded; the receiver cannot stall
module concat_device_address_map #(
  parameter int MAX_DEVICES = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_op,
  input  logic [cdam_pkg::ENTRY_W-1:0] in_entry_index,
  input  logic [cdam_pkg::ADDR_W-1:0] in_entry_base,
  input  logic [cdam_pkg::SIZE_W-1:0] in_entry_size,
  input  logic [cdam_pkg::ADDR_W-1:0] in_query_value,
  output logic                        out_valid,
  output logic [cdam_pkg::ADDR_W-1:0] out_result_value,
  output logic                        out_found,
  output logic [cdam_pkg::HIT_W-1:0]  out_device_hit,
  input  logic                        cfg_we,
  input  logic [cdam_pkg::CNT_W-1:0]  cfg_wdata
);

  localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int SUM_W = cdam_pkg::SIZE_W + $clog2(MAX_DEVICES) + 1;

  logic                         acc;
  cdam_pkg::op_t                in_op_w;
  logic                         busy_r, busy_nxt;
  logic [cdam_pkg::CNT_W-1:0]   count_r;
  cdam_pkg::stage_ctl_t         s0_ctl_r;
  logic [cdam_pkg::ADDR_W-1:0]  s0_query_r;
  logic [cdam_pkg::ENTRY_W-1:0] s0_idx_r;
  logic [cdam_pkg::ADDR_W-1:0]  s0_base_r;
  logic [cdam_pkg::SIZE_W-1:0]  s0_size_r;
  cdam_pkg::tbl_wr_t            s0_wr;
  cdam_pkg::stage_ctl_t         s2_ctl;
  cdam_pkg::tbl_wr_t            s2_wr;
  logic                         s2_found;
  logic [IDX_W-1:0]             s2_idx;
  logic [cdam_pkg::SIZE_W-1:0]  s2_diff;
  logic [cdam_pkg::ADDR_W-1:0]  base_q   [MAX_DEVICES];
  logic [cdam_pkg::SIZE_W-1:0]  size_q   [MAX_DEVICES];
  logic [SUM_W-1:0]             prefix_q [MAX_DEVICES];
  logic [cdam_pkg::ADDR_W-1:0]  rd_base;
  logic [SUM_W-1:0]             rd_prefix;
  logic                         sweep_last;
  logic [cdam_pkg::ADDR_W-1:0]  addend_w, sum_w;
  logic                         out_valid_r;
  logic [cdam_pkg::ADDR_W-1:0]  out_result_r;
  logic                         out_found_r;
  logic [cdam_pkg::HIT_W-1:0]   out_hit_r;

  assign in_op_w = cdam_pkg::op_t'(in_op);
  assign acc     = start && !busy_r;

  // device count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= cdam_pkg::CNT_RESET;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  // busy from a load transfer until the prefix rebuild ends
  always_comb begin
    busy_nxt = busy_r;
    priority if (acc && (in_op_w == cdam_pkg::OP_LOAD)) begin
      busy_nxt = 1'b1;
    end else if (sweep_last) begin
      busy_nxt = 1'b0;
    end else begin
      busy_nxt = busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (acc) begin
      s0_ctl_r.op <= in_op_w;
      s0_query_r  <= in_query_value;
      s0_idx_r    <= in_entry_index;
      s0_base_r   <= in_entry_base;
      s0_size_r   <= in_entry_size;
    end
    if (!rst_n) begin
      s0_ctl_r.vld <= 1'b0;
    end else begin
      s0_ctl_r.vld <= acc;
    end
  end

  assign s0_wr = {s0_ctl_r.vld && (s0_ctl_r.op == cdam_pkg::OP_LOAD),
                  s0_idx_r, s0_base_r, s0_size_r};

  cdam_table #(
    .MAX_DEVICES(MAX_DEVICES)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (s2_wr),
    .rd_idx    (s2_idx),
    .base_q    (base_q),
    .size_q    (size_q),
    .prefix_q  (prefix_q),
    .rd_base   (rd_base),
    .rd_prefix (rd_prefix),
    .sweep_last(sweep_last)
  );

  cdam_match #(
    .MAX_DEVICES(MAX_DEVICES)
  ) u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .s0_ctl   (s0_ctl_r),
    .s0_query (s0_query_r),
    .s0_wr    (s0_wr),
    .dev_count(count_r),
    .base_q   (base_q),
    .size_q   (size_q),
    .prefix_q (prefix_q),
    .s2_ctl   (s2_ctl),
    .s2_wr    (s2_wr),
    .s2_found (s2_found),
    .s2_idx   (s2_idx),
    .s2_diff  (s2_diff)
  );

  // translate: device base or running offset plus distance into the window
  assign addend_w = (s2_ctl.op == cdam_pkg::OP_FWD) ? rd_base : cdam_pkg::ADDR_W'(rd_prefix);
  assign sum_w    = addend_w + cdam_pkg::ADDR_W'(s2_diff);

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r  <= s2_found;
    out_result_r <= s2_found ? sum_w : cdam_pkg::ALL_ONES;
    out_hit_r    <= s2_found ? cdam_pkg::HIT_W'(s2_idx) : '0;
  end

  assign busy             = busy_r;
  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_r;
  assign out_found        = out_found_r;
  assign out_device_hit   = out_hit_r;

  // a load transfer raises busy straight away
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_op_w == cdam_pkg::OP_LOAD)) |=> busy)
    else $error("busy not raised after load transfer");

  // every transfer is followed by its result on out_valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##4 out_valid)
    else $error("result missing four cycles after transfer");

  // a miss carries all ones and device zero
  a_miss_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |->
      (out_result_value == cdam_pkg::ALL_ONES) && (out_device_hit == '0))
    else $error("miss result not all ones with device zero");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the concatenated device address map
module tb;

  localparam int MAP_DEPTH      = 8;
  localparam int DRAIN_CYCLES   = MAP_DEPTH + 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 125;

  typedef struct packed {
    cdam_pkg::op_t                op;
    logic [cdam_pkg::ENTRY_W-1:0] idx;
    logic [cdam_pkg::ADDR_W-1:0]  base;
    logic [cdam_pkg::SIZE_W-1:0]  size;
    logic [cdam_pkg::ADDR_W-1:0]  query;
  } map_item_t;

  typedef struct packed {
    logic [cdam_pkg::ADDR_W-1:0] value;
    logic                        found;
    logic [cdam_pkg::HIT_W-1:0]  hit;
  } map_result_t;

  logic                         clk            = 1'b0;
  logic                         rst_n          = 1'b0;
  logic                         start          = 1'b0;
  logic                         busy;
  logic [1:0]                   in_op          = '0;
  logic [cdam_pkg::ENTRY_W-1:0] in_entry_index = '0;
  logic [cdam_pkg::ADDR_W-1:0]  in_entry_base  = '0;
  logic [cdam_pkg::SIZE_W-1:0]  in_entry_size  = '0;
  logic [cdam_pkg::ADDR_W-1:0]  in_query_value = '0;
  logic                         out_valid;
  logic [cdam_pkg::ADDR_W-1:0]  out_result_value;
  logic                         out_found;
  logic [cdam_pkg::HIT_W-1:0]   out_device_hit;
  logic                         cfg_we         = 1'b0;
  logic [cdam_pkg::CNT_W-1:0]   cfg_wdata      = '0;

  // predicted table and device count
  logic [cdam_pkg::ADDR_W-1:0] map_base [MAP_DEPTH];
  logic [cdam_pkg::SIZE_W-1:0] map_size [MAP_DEPTH];
  logic [cdam_pkg::CNT_W-1:0]  map_count = cdam_pkg::CNT_RESET;

  // table as the stimulus will have left it, used to aim queries at devices
  logic [cdam_pkg::ADDR_W-1:0] plan_base [MAP_DEPTH];
  logic [cdam_pkg::SIZE_W-1:0] plan_size [MAP_DEPTH];

  map_item_t   item_queue[$];
  map_result_t expected_results[$];
  map_item_t   cur_item;
  map_result_t want;

  int outstanding     = 0;
  int fail_count      = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int count_settings  = 0;
  int burst_left      = 0;
  int gap_left        = 0;
  int idle_cycles     = 0;

  concat_device_address_map #(
    .MAX_DEVICES(MAP_DEPTH)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_entry_index  (in_entry_index),
    .in_entry_base   (in_entry_base),
    .in_entry_size   (in_entry_size),
    .in_query_value  (in_query_value),
    .out_valid       (out_valid),
    .out_result_value(out_result_value),
    .out_found       (out_found),
    .out_device_hit  (out_device_hit),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // translation of one item against the predicted table
  function automatic map_result_t map_translate(input map_item_t it);
    map_result_t                 r;
    logic [cdam_pkg::ADDR_W-1:0] span;
    logic [cdam_pkg::ADDR_W-1:0] sz;
    int                          n;
    int                          i;
    r.value = cdam_pkg::ALL_ONES;
    r.found = 1'b0;
    r.hit   = '0;
    span    = '0;
    n = (int'(map_count) > MAP_DEPTH) ? MAP_DEPTH : int'(map_count);
    case (it.op)
      cdam_pkg::OP_LOAD: begin
        map_base[it.idx] = it.base;
        map_size[it.idx] = it.size;
      end
      cdam_pkg::OP_FWD: begin
        for (i = 0; i < n; i++) begin
          sz = cdam_pkg::ADDR_W'(map_size[i]);
          if (!r.found && it.query >= span && it.query - span < sz) begin
            r.value = map_base[i] + (it.query - span);
            r.found = 1'b1;
            r.hit   = cdam_pkg::HIT_W'(i);
          end
          span += sz;
        end
      end
      cdam_pkg::OP_REV: begin
        // window test by subtraction, so a window past the top does not wrap
        for (i = 0; i < n; i++) begin
          sz = cdam_pkg::ADDR_W'(map_size[i]);
          if (!r.found && it.query >= map_base[i] && it.query - map_base[i] < sz) begin
            r.value = span + (it.query - map_base[i]);
            r.found = 1'b1;
            r.hit   = cdam_pkg::HIT_W'(i);
          end
          span += sz;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [cdam_pkg::ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic map_item_t make_item(input cdam_pkg::op_t op, input int idx,
                                          input logic [cdam_pkg::ADDR_W-1:0] base,
                                          input logic [cdam_pkg::SIZE_W-1:0] size,
                                          input logic [cdam_pkg::ADDR_W-1:0] query);
    map_item_t it;
    it.op    = op;
    it.idx   = cdam_pkg::ENTRY_W'(idx);
    it.base  = base;
    it.size  = size;
    it.query = query;
    return it;
  endfunction

  // random item, mostly queries aimed at device edges and interiors
  function automatic map_item_t random_item();
    map_item_t                   it;
    logic [cdam_pkg::ADDR_W-1:0] span;
    logic [cdam_pkg::ADDR_W-1:0] sz;
    logic [cdam_pkg::ADDR_W-1:0] delta;
    int                          n;
    int                          dev;
    int                          pick;
    int                          i;
    it.op    = cdam_pkg::OP_FWD;
    it.idx   = cdam_pkg::ENTRY_W'($urandom_range(0, MAP_DEPTH - 1));
    it.base  = rand64();
    it.size  = cdam_pkg::SIZE_W'(rand64());
    it.query = rand64();
    n = (int'(map_count) > MAP_DEPTH) ? MAP_DEPTH : int'(map_count);
    pick = $urandom_range(0, 99);
    if (pick >= 10 && pick < 80 && n == 0) pick = 80;
    if (pick < 10) begin
      it.op = cdam_pkg::OP_LOAD;
      case ($urandom_range(0, 5))
        0:       it.size = '0;
        1:       it.size = '1;
        2, 3:    it.size = cdam_pkg::SIZE_W'($urandom_range(1, 4096));
        default: ;
      endcase
      case ($urandom_range(0, 3))
        0:       it.base = {48'hFFFF_FFFF_FFFF, 16'($urandom)};
        1:       it.base = cdam_pkg::ADDR_W'($urandom_range(0, 65535));
        default: ;
      endcase
    end else if (pick < 80) begin
      dev  = $urandom_range(0, n - 1);
      span = '0;
      for (i = 0; i < dev; i++) span += cdam_pkg::ADDR_W'(plan_size[i]);
      sz = cdam_pkg::ADDR_W'(plan_size[dev]);
      // first byte, last byte, one past the end, or somewhere inside
      case ($urandom_range(0, 4))
        0:       delta = '0;
        1:       delta = sz - 1;
        2:       delta = sz;
        default: delta = (sz == '0) ? '0 : rand64() % sz;
      endcase
      if (pick < 45) begin
        it.op    = cdam_pkg::OP_FWD;
        it.query = span + delta;
      end else begin
        it.op    = cdam_pkg::OP_REV;
        it.query = plan_base[dev] + delta;
      end
    end else if (pick < 95) begin
      it.op = ($urandom_range(0, 1) == 0) ? cdam_pkg::OP_FWD : cdam_pkg::OP_REV;
    end else begin
      it.op = cdam_pkg::OP_NONE;
    end
    return it;
  endfunction

  task automatic queue_item(input map_item_t it);
    if (it.op == cdam_pkg::OP_LOAD) begin
      plan_base[it.idx] = it.base;
      plan_size[it.idx] = it.size;
    end
    outstanding++;
    item_queue.push_back(it);
  endtask

  task automatic wait_drained();
    while (outstanding > 0) @(posedge clk);
    // let a load's table rebuild finish before touching the register
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_device_count(input logic [cdam_pkg::CNT_W-1:0] n);
    cfg_wdata <= n;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    map_count = n;
    count_settings++;
  endtask

  // driver: one item per transfer, bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(map_translate(cur_item));
        items_sent++;
      end
      if (!start || !busy) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (gap_left > 0 || item_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          start <= 1'b0;
        end else begin
          cur_item = item_queue.pop_front();
          in_op          <= cur_item.op;
          in_entry_index <= cur_item.idx;
          in_entry_base  <= cur_item.base;
          in_entry_size  <= cur_item.size;
          in_query_value <= cur_item.query;
          start          <= 1'b1;
          burst_left--;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_checked++;
      outstanding--;
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing predicted: value %h found %b hit %0d",
               out_result_value, out_found, out_device_hit);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_result_value !== want.value) begin
          $error("result_value: expected %h, actual %h", want.value, out_result_value);
          fail_count++;
        end
        if (out_found !== want.found) begin
          $error("found: expected %b, actual %b", want.found, out_found);
          fail_count++;
        end
        if (out_device_hit !== want.hit) begin
          $error("device_hit: expected %0d, actual %0d", want.hit, out_device_hit);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $error("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // stimulus and phase control
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // fill every entry first so no query ever reads an unwritten one
    queue_item(make_item(cdam_pkg::OP_LOAD, 0, 64'h1000, 48'h100, '0));
    queue_item(make_item(cdam_pkg::OP_LOAD, 1, '0, '0, '1));
    queue_item(make_item(cdam_pkg::OP_LOAD, 2, 64'hFFFF_FFFF_FFFF_FF00, 48'h200, '0));
    queue_item(make_item(cdam_pkg::OP_LOAD, 3, 64'h1080, 48'h100, '0));
    queue_item(make_item(cdam_pkg::OP_LOAD, 4, '0, '1, '0));
    queue_item(make_item(cdam_pkg::OP_LOAD, 5, '1, 48'h1, '0));
    queue_item(make_item(cdam_pkg::OP_LOAD, 6, 64'h8000_0000_0000_0000, 48'h10, '0));
    queue_item(make_item(cdam_pkg::OP_LOAD, 7, 64'h5555_5555_5555_5555, 48'h1234, '0));

    // reset count: only entry zero in use
    queue_item(make_item(cdam_pkg::OP_FWD, 0, '0, '0, 64'h0));
    queue_item(make_item(cdam_pkg::OP_FWD, 0, '0, '0, 64'hFF));
    queue_item(make_item(cdam_pkg::OP_FWD, 0, '0, '0, 64'h100));
    queue_item(make_item(cdam_pkg::OP_REV, 0, '0, '0, 64'h1000));
    queue_item(make_item(cdam_pkg::OP_REV, 0, '0, '0, 64'h0FFF));
    queue_item(make_item(cdam_pkg::OP_NONE, 7, '1, '1, '1));

    // full table: zero size, wrapping window, overlap, end of the space
    wait_drained();
    set_device_count(cdam_pkg::CNT_W'(MAP_DEPTH));
    queue_item(make_item(cdam_pkg::OP_FWD, 0, '0, '0, 64'h100));
    queue_item(make_item(cdam_pkg::OP_FWD, 0, '0, '0, 64'h2FF));
    queue_item(make_item(cdam_pkg::OP_FWD, 0, '0, '0, 64'h1_0000_0000_1643));
    queue_item(make_item(cdam_pkg::OP_FWD, 0, '0, '0, 64'h1_0000_0000_1644));
    queue_item(make_item(cdam_pkg::OP_REV, 0, '0, '0, 64'h1080));
    queue_item(make_item(cdam_pkg::OP_REV, 0, '0, '0, '1));
    queue_item(make_item(cdam_pkg::OP_REV, 0, '0, '0, 64'h0));
    queue_item(make_item(cdam_pkg::OP_REV, 0, '0, '0, 64'h8000_0000_0000_0010));

    // no devices in use
    wait_drained();
    set_device_count('0);
    queue_item(make_item(cdam_pkg::OP_FWD, 0, '0, '0, 64'h0));
    queue_item(make_item(cdam_pkg::OP_REV, 0, '0, '0, 64'h1000));

    // count above the table depth saturates
    wait_drained();
    set_device_count('1);
    queue_item(make_item(cdam_pkg::OP_FWD, 0, '0, '0, '1));
    queue_item(make_item(cdam_pkg::OP_REV, 0, '0, '0, 64'h0));

    // random phases, extremes of the count first
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0:       set_device_count(cdam_pkg::CNT_W'(MAP_DEPTH));
        1:       set_device_count(cdam_pkg::CNT_W'(1));
        2:       set_device_count('0);
        3:       set_device_count('1);
        default: set_device_count(cdam_pkg::CNT_W'($urandom_range(0, 15)));
      endcase
      repeat (PHASE_ITEMS) queue_item(random_item());
    end

    wait_drained();
    if (expected_results.size() != 0) begin
      $error("%0d predicted results never arrived", expected_results.size());
      fail_count++;
    end
    $display("run: %0d items transferred, %0d results checked, %0d device count writes",
             items_sent, results_checked, count_settings);
    $display("covered loads, forward and reverse lookups, unused op, counts 0, 1, 8 and 15");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
